// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the loader core RTL. In a synthesis run
// they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent holds at an edge, so the consequent holds at the same edge.
`define HXL_ASSERT_IMP(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |-> (cons)) else $error(msg);

// Antecedent holds at an edge, so the consequent holds at the next edge.
`define HXL_ASSERT_NXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |=> (cons)) else $error(msg);

`else

`define HXL_ASSERT_IMP(label, clock, resetn, ante, cons, msg)
`define HXL_ASSERT_NXT(label, clock, resetn, ante, cons, msg)

`endif

`endif

// File: design/hxl_pkg.sv
// ----------------------------------------------------------------------------
// hxl_pkg
// Types, character codes and parsing functions of the hex text loader.
// ----------------------------------------------------------------------------
package hxl_pkg;

    // One input beat: a character and its end-of-line mark.
    typedef struct packed {
        logic [7:0] text_char;
        logic       line_end;
    } in_item_t;

    // One result beat: a byte write to the 64K memory.
    typedef struct packed {
        logic [15:0] write_address;
        logic [7:0]  write_data;
    } out_item_t;

    // Result of one parser step, handed to the output register.
    typedef struct packed {
        logic      hit;
        out_item_t item;
    } emit_t;

    // Classification of the current line.
    typedef enum logic [3:0] {
        KIND_START     = 4'b0001,
        KIND_UNDECIDED = 4'b0010,
        KIND_RECORD    = 4'b0100,
        KIND_MONITOR   = 4'b1000
    } line_kind_t;

    // Monitor-format working state plus the first write of a step.
    typedef struct packed {
        logic [15:0] load_address;
        logic [7:0]  data_value;
        logic        value_pending;
        logic        address_mode;
        logic        emitted;
        logic [15:0] emit_address;
        logic [7:0]  emit_data;
    } mon_t;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    localparam logic [9:0] POS_MAX          = 10'd1023;
    localparam logic [9:0] POS_PREFIX_FIRST = 10'd1;
    localparam logic [9:0] POS_PREFIX_LAST  = 10'd4;
    localparam logic [9:0] POS_ADDR_LO      = 10'd6;
    localparam logic [9:0] POS_TYPE_HI      = 10'd7;
    localparam logic [9:0] POS_TYPE_LO      = 10'd8;
    localparam logic [9:0] POS_DATA_FIRST   = 10'd9;
    // Half of the position of the first data byte's low digit.
    localparam logic [8:0] BYTE_INDEX_BASE  = 9'd5;
    localparam logic [7:0] RECORD_TYPE_DATA = 8'h00;

    function automatic logic is_hex(logic [7:0] c);
        return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) ||
               ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F));
    endfunction

    // Nibble value of a hex digit; any other character reads as zero.
    function automatic logic [3:0] nib(logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
            d = c - CHAR_ZERO;
        end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
            d = c - CHAR_LOWER_A + HEX_LETTER_BASE;
        end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
            d = c - CHAR_UPPER_A + HEX_LETTER_BASE;
        end
        return d[3:0];
    endfunction

    // A write: only the first of a step is kept, the address always advances.
    function automatic mon_t mon_emit(mon_t s);
        mon_t r;
        r = s;
        if (!r.emitted) begin
            r.emitted      = 1'b1;
            r.emit_address = r.load_address;
            r.emit_data    = r.data_value;
        end
        r.load_address = r.load_address + 16'd1;
        return r;
    endfunction

    // One character in monitor format.
    function automatic mon_t mon_char(mon_t s, logic [7:0] c);
        mon_t r;
        r = s;
        if (c == CHAR_COLON) begin
            if (r.value_pending) begin
                r = mon_emit(r);
            end
            r.value_pending = 1'b0;
            r.address_mode  = 1'b1;
            r.load_address  = '0;
        end else if (c == CHAR_SPACE) begin
            if (r.value_pending && !r.address_mode) begin
                r = mon_emit(r);
            end
            r.value_pending = 1'b0;
            r.address_mode  = 1'b0;
            r.data_value    = '0;
        end else if (is_hex(c)) begin
            if (r.address_mode) begin
                r.load_address = {r.load_address[11:0], nib(c)};
            end else begin
                r.data_value = {r.data_value[3:0], nib(c)};
            end
            r.value_pending = 1'b1;
        end
        return r;
    endfunction

    // Line end: flush pending data and clear the pending flag.
    function automatic mon_t mon_end(mon_t s);
        mon_t r;
        r = s;
        if (r.value_pending) begin
            r = mon_emit(r);
        end
        r.value_pending = 1'b0;
        return r;
    endfunction

endpackage

// File: design/hxl_parser.sv
// ----------------------------------------------------------------------------
// hxl_parser
// Line state and one-character parse step; holds the loader's parse state.
// ----------------------------------------------------------------------------
module hxl_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  hxl_pkg::in_item_t item,
    output hxl_pkg::emit_t   emit
);
    import hxl_pkg::*;

    logic [9:0]  line_position_reg, line_position_next;
    line_kind_t  line_kind_reg, line_kind_next;
    logic [7:0]  prefix_reg [4];
    logic [15:0] load_address_reg;
    logic [7:0]  data_value_reg;
    logic        value_pending_reg;
    logic        address_mode_reg;
    logic [7:0]  record_length_reg, record_length_next;
    logic [7:0]  record_type_reg, record_type_next;
    logic [15:0] record_address_reg, record_address_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;

    logic        prefix_we;
    logic [1:0]  prefix_idx;
    logic [7:0]  c;
    logic [3:0]  v;
    logic [8:0]  byte_idx;
    mon_t        m;

    always_comb
    begin
        c          = item.text_char;
        v          = nib(c);
        prefix_idx = line_position_reg[1:0] - 2'd1;
        prefix_we  = 1'b0;
        byte_idx   = line_position_reg[9:1] - BYTE_INDEX_BASE;

        m.load_address  = load_address_reg;
        m.data_value    = data_value_reg;
        m.value_pending = value_pending_reg;
        m.address_mode  = address_mode_reg;
        m.emitted       = 1'b0;
        m.emit_address  = '0;
        m.emit_data     = '0;

        line_kind_next      = line_kind_reg;
        record_length_next  = record_length_reg;
        record_type_next    = record_type_reg;
        record_address_next = record_address_reg;
        high_nibble_next    = high_nibble_reg;

        unique case (line_kind_reg)
            KIND_START:
            begin
                if (c == CHAR_COLON) begin
                    line_kind_next = KIND_UNDECIDED;
                end else begin
                    line_kind_next = KIND_MONITOR;
                    m = mon_char(m, c);
                end
            end
            KIND_UNDECIDED:
            begin
                if ((line_position_reg >= POS_PREFIX_FIRST) &&
                    (line_position_reg <= POS_PREFIX_LAST)) begin
                    prefix_we = 1'b1;
                end else if (c == CHAR_SPACE) begin
                    // Not a record after all: replay the held text as monitor input.
                    line_kind_next = KIND_MONITOR;
                    m = mon_char(m, CHAR_COLON);
                    for (int i = 0; i < 4; i++) begin
                        m = mon_char(m, prefix_reg[i]);
                    end
                    m = mon_char(m, c);
                end else begin
                    line_kind_next      = KIND_RECORD;
                    record_length_next  = {nib(prefix_reg[0]), nib(prefix_reg[1])};
                    record_address_next = {nib(prefix_reg[2]), nib(prefix_reg[3]), 8'h00};
                    high_nibble_next    = v;
                end
            end
            KIND_RECORD:
            begin
                if (line_position_reg == POS_ADDR_LO) begin
                    record_address_next = {record_address_reg[15:8], high_nibble_reg, v};
                    if (record_length_reg != 8'd0) begin
                        m.load_address = record_address_next;
                    end
                end else if (line_position_reg == POS_TYPE_HI) begin
                    high_nibble_next = v;
                end else if (line_position_reg == POS_TYPE_LO) begin
                    record_type_next = {high_nibble_reg, v};
                end else if (line_position_reg >= POS_DATA_FIRST) begin
                    if (line_position_reg[0]) begin
                        high_nibble_next = v;
                    end else if ((record_length_reg != 8'd0) &&
                                 (record_type_reg == RECORD_TYPE_DATA) &&
                                 (byte_idx < {1'b0, record_length_reg})) begin
                        m.data_value = {high_nibble_reg, v};
                        m = mon_emit(m);
                    end
                end
            end
            KIND_MONITOR:
            begin
                m = mon_char(m, c);
            end
            default:
            begin
                line_kind_next = KIND_START;
            end
        endcase

        if (item.line_end) begin
            m                  = mon_end(m);
            line_kind_next     = KIND_START;
            line_position_next = '0;
        end else if (line_position_reg < POS_MAX) begin
            line_position_next = line_position_reg + 10'd1;
        end else begin
            line_position_next = line_position_reg;
        end

        emit.hit                = m.emitted;
        emit.item.write_address = m.emit_address;
        emit.item.write_data    = m.emit_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_position_reg  <= '0;
            line_kind_reg      <= KIND_START;
            load_address_reg   <= '0;
            data_value_reg     <= '0;
            value_pending_reg  <= 1'b0;
            address_mode_reg   <= 1'b0;
            record_length_reg  <= '0;
            record_type_reg    <= '0;
            record_address_reg <= '0;
            high_nibble_reg    <= '0;
        end else if (step) begin
            line_position_reg  <= line_position_next;
            line_kind_reg      <= line_kind_next;
            load_address_reg   <= m.load_address;
            data_value_reg     <= m.data_value;
            value_pending_reg  <= m.value_pending;
            address_mode_reg   <= m.address_mode;
            record_length_reg  <= record_length_next;
            record_type_reg    <= record_type_next;
            record_address_reg <= record_address_next;
            high_nibble_reg    <= high_nibble_next;
        end
    end

    // The held characters of a ':' line are always written before use.
    always_ff @(posedge clk)
    begin
        if (step && prefix_we) begin
            prefix_reg[prefix_idx] <= c;
        end
    end

endmodule

// File: design/hxl_out_stage.sv
// ----------------------------------------------------------------------------
// hxl_out_stage
// Result register for write beats, with the free flag for the parse stage.
// ----------------------------------------------------------------------------
module hxl_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hxl_pkg::out_item_t item,
    output logic              free,
    output logic              wr_valid,
    input  logic              wr_stall,
    output hxl_pkg::out_item_t wr_beat
);
    import hxl_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t beat_reg;

    assign free = !valid_reg || !wr_stall;

    always_comb
    begin
        if (load) begin
            valid_next = 1'b1;
        end else if (!wr_stall) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            beat_reg <= item;
        end
    end

    assign wr_valid = valid_reg;
    assign wr_beat  = beat_reg;

endmodule

// File: design/hex_text_memory_loader_core.sv
// ----------------------------------------------------------------------------
// hex_text_memory_loader_core
// Turns a character stream into byte writes for a 64K memory.
// ----------------------------------------------------------------------------
// The loader takes one character beat per clock while no blocked write holds
// it back, and answers with at most one write beat per character. A line
// that starts with ':' is read as an Intel hex record unless its sixth
// character is a space; the ':' and the four held characters are then
// replayed in monitor format in that same cycle. Record lines write the data
// bytes of type-0 records from the record address up and ignore the checksum;
// monitor lines use ':' to start an address, hex digits to shift in address
// or data, and a space or the line end to write the pending byte. A character
// waits in the input register until the result register is free; the parser
// then works out its effect and updates the line state, and any write is
// loaded into the result register at the end of that parse step, so a write
// beat reaches the write side through the input and result registers. The
// result register decouples the write side: while a write waits to be taken,
// a character that is already held waits too, but the stream keeps flowing
// whenever the write side does.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_text_memory_loader_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  hxl_pkg::in_item_t  char_beat,
    output logic               wr_valid,
    input  logic               wr_stall,
    output hxl_pkg::out_item_t wr_beat
);
    import hxl_pkg::*;

    // Input register: one character waiting for its parse step.
    logic     item_vld_reg, item_vld_next;
    in_item_t item_reg;

    logic     accept;
    logic     step;
    logic     out_free;
    emit_t    emit;

    // The held character is parsed as soon as the result register can take
    // whatever write it may cause.
    assign step       = item_vld_reg && out_free;
    assign char_stall = item_vld_reg && !out_free;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        if (accept) begin
            item_vld_next = 1'b1;
        end else if (step) begin
            item_vld_next = 1'b0;
        end else begin
            item_vld_next = item_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_vld_reg <= 1'b0;
        end else begin
            item_vld_reg <= item_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg <= char_beat;
        end
    end

    hxl_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .emit  (emit)
    );

    hxl_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && emit.hit),
        .item     (emit.item),
        .free     (out_free),
        .wr_valid (wr_valid),
        .wr_stall (wr_stall),
        .wr_beat  (wr_beat)
    );

    // The input side only stalls while a character is held behind a blocked write.
    `HXL_ASSERT_IMP(a_stall_cause, clk, rst_n, char_stall, item_vld_reg && wr_valid && wr_stall, "char_stall without a blocked write")
    // A parse step that writes shows that write on the next cycle.
    `HXL_ASSERT_NXT(a_write_lands, clk, rst_n, step && emit.hit, wr_valid && (wr_beat == $past(emit.item)), "parsed write not presented")
    // A new write beat only follows a parse step that produced it.
    `HXL_ASSERT_IMP(a_write_source, clk, rst_n, $rose(wr_valid), $past(step && emit.hit), "write beat without a parse step")

endmodule
